@@ design/rct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster contour tracer package
// Shared sizes, codes, state type and coordinate helpers for the tracer.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  localparam int POS_W   = 7;
  localparam int SIZE_W  = 8;
  localparam int COLOR_W = 24;
  localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_AW    = $clog2(PIX_DEPTH);

  localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [1:0] ST_POINT = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_IDLE  = 2'd3;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  localparam logic [2:0] PROBE_FIRST     = 3'd0;
  localparam logic [2:0] PROBE_SCAN_LAST = 3'd4;
  localparam logic [2:0] PROBE_CAND_LAST = 3'd6;
  localparam logic [2:0] PROBE_STEP_LAST = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STEP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] c;
    logic [SIZE_W-1:0] r;
  } coord_t;

  // Neighbor coordinate one pixel away; minus one past the edge wraps to all ones.
  function automatic coord_t probe_coord(input logic [POS_W-1:0] c,
                                         input logic [POS_W-1:0] r,
                                         input logic [1:0] dir);
    coord_t p;
    p.c = {1'b0, c};
    p.r = {1'b0, r};
    case (dir)
      DIR_RIGHT: p.c = p.c + SIZE_W'(1);
      DIR_DOWN:  p.r = p.r + SIZE_W'(1);
      DIR_LEFT:  p.c = p.c - SIZE_W'(1);
      DIR_UP:    p.r = p.r - SIZE_W'(1);
      default:   p.c = p.c;
    endcase
    return p;
  endfunction

  function automatic logic [PIX_AW-1:0] pix_addr(input logic [POS_W-1:0] c,
                                                 input logic [POS_W-1:0] r);
    return PIX_AW'(r) * PIX_AW'(MAX_WIDTH) + PIX_AW'(c);
  endfunction

endpackage

@@ design/rct_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rct_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/raster_contour_tracer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster contour tracer
// Pixel store with a start-point scan and a turn-left-first boundary walk.
// ----------------------------------------------------------------------------
//  Channel   Ports                                        Beat
//  input     in_valid/in_stall, in_op..in_color           load, start or step
//  result    out_valid/out_stall, out_status..out_stuck   one per start or step
//  config    cfg_write_en, cfg_index, cfg_data            register write
//
// A load is a single memory write. Every pixel probe is one read of the
// pixel memory's single read port: a step takes up to eight probes, a start
// takes one to five probes per scanned pixel.
// Reset needs no clearing pass; pixels read before being written are undefined.
// The input is stalled while a start or step is in progress; a result waiting
// on the output does not block loads or the next item's probing.
module raster_contour_tracer_unit
  import rct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [POS_W-1:0]   in_column,
  input  logic [POS_W-1:0]   in_row,
  input  logic [COLOR_W-1:0] in_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [POS_W-1:0]   out_point_column,
  output logic [POS_W-1:0]   out_point_row,
  output logic               out_last,
  output logic               out_stuck,
  input  logic               cfg_write_en,
  input  logic               cfg_index,
  input  logic [SIZE_W-1:0]  cfg_data
);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  width_r, height_r;
  logic               tracing_r, tracing_nxt;
  logic [POS_W-1:0]   cur_c_r, cur_c_nxt, cur_r_r, cur_r_nxt;
  logic [POS_W-1:0]   init_c_r, init_c_nxt, init_r_r, init_r_nxt;
  logic [1:0]         heading_r, heading_nxt;
  logic [COLOR_W-1:0] target_r, target_nxt;

  logic [POS_W-1:0]   base_c_r, base_c_nxt, base_r_r, base_r_nxt;
  logic [POS_W-1:0]   scan_c0_r, scan_c0_nxt;
  logic [2:0]         probe_k_r, probe_k_nxt;
  logic               probe_in_r, probe_in_nxt;

  logic [1:0]         pend_status_r, pend_status_nxt;
  logic [POS_W-1:0]   pend_c_r, pend_c_nxt, pend_r_r, pend_r_nxt;
  logic               pend_last_r, pend_last_nxt, pend_stuck_r, pend_stuck_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [POS_W-1:0]   out_c_r, out_c_nxt, out_r_r, out_r_nxt;
  logic               out_last_r, out_last_nxt, out_stuck_r, out_stuck_nxt;

  logic [SIZE_W-1:0]  used_w, used_h;
  logic [COLOR_W-1:0] rd_data;
  logic [PIX_AW-1:0]  rd_addr;
  logic               ram_we;
  logic               accept, start_ok, hit, out_free;
  logic               col_end, row_end;
  logic               scan_miss, scan_found, scan_none, step_move, step_stuck;
  logic               center;
  logic [1:0]         probe_dir, cand_dir;
  coord_t             probe_pos, cand_pos;
  logic               back;

  assign used_w   = (width_r > MAX_W_SZ) ? MAX_W_SZ : width_r;
  assign used_h   = (height_r > MAX_H_SZ) ? MAX_H_SZ : height_r;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign start_ok = ({1'b0, in_column} < used_w) && ({1'b0, in_row} < used_h);
  assign hit      = probe_in_r && (rd_data == target_r);
  assign out_free = !out_valid_r || !out_stall;
  assign col_end  = ({1'b0, base_c_r} + SIZE_W'(1)) >= used_w;
  assign row_end  = ({1'b0, base_r_r} + SIZE_W'(1)) >= used_h;

  assign cand_dir = 2'(heading_r + 2'd3 + probe_k_r[2:1]);
  assign cand_pos = probe_coord(base_c_r, base_r_r, cand_dir);
  assign back     = (cand_pos.c == {1'b0, init_c_r}) && (cand_pos.r == {1'b0, init_r_r});

  always_comb begin
    scan_miss  = (state_r == S_SCAN) &&
                 (((probe_k_r == PROBE_FIRST) && !hit) ||
                  ((probe_k_r == PROBE_SCAN_LAST) && hit));
    scan_found = (state_r == S_SCAN) && (probe_k_r != PROBE_FIRST) && !hit;
    scan_none  = scan_miss && col_end && row_end;
    step_move  = (state_r == S_STEP) && probe_k_r[0] && !hit;
    step_stuck = (state_r == S_STEP) &&
                 (((probe_k_r == PROBE_CAND_LAST) && !hit) ||
                  ((probe_k_r == PROBE_STEP_LAST) && hit));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_START) begin
          state_nxt = start_ok ? S_SCAN : S_EMIT;
        end else if (accept && in_op == OP_STEP) begin
          state_nxt = tracing_r ? S_STEP : S_EMIT;
        end
      end
      S_SCAN: begin
        if (scan_found || scan_none) begin
          state_nxt = S_EMIT;
        end
      end
      S_STEP: begin
        if (step_move || step_stuck) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tracing_nxt     = tracing_r;
    cur_c_nxt       = cur_c_r;
    cur_r_nxt       = cur_r_r;
    init_c_nxt      = init_c_r;
    init_r_nxt      = init_r_r;
    heading_nxt     = heading_r;
    target_nxt      = target_r;
    base_c_nxt      = base_c_r;
    base_r_nxt      = base_r_r;
    scan_c0_nxt     = scan_c0_r;
    probe_k_nxt     = probe_k_r;
    pend_status_nxt = pend_status_r;
    pend_c_nxt      = pend_c_r;
    pend_r_nxt      = pend_r_r;
    pend_last_nxt   = pend_last_r;
    pend_stuck_nxt  = pend_stuck_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_c_nxt       = out_c_r;
    out_r_nxt       = out_r_r;
    out_last_nxt    = out_last_r;
    out_stuck_nxt   = out_stuck_r;
    ram_we          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_LOAD: begin
              ram_we = ({1'b0, in_column} < MAX_W_SZ) && ({1'b0, in_row} < MAX_H_SZ);
            end
            OP_START: begin
              target_nxt      = in_color;
              tracing_nxt     = 1'b0;
              base_c_nxt      = in_column;
              base_r_nxt      = in_row;
              scan_c0_nxt     = in_column;
              probe_k_nxt     = PROBE_FIRST;
              pend_status_nxt = ST_NONE;
              pend_c_nxt      = '0;
              pend_r_nxt      = '0;
              pend_last_nxt   = 1'b0;
              pend_stuck_nxt  = 1'b0;
            end
            OP_STEP: begin
              base_c_nxt      = cur_c_r;
              base_r_nxt      = cur_r_r;
              probe_k_nxt     = PROBE_FIRST;
              pend_status_nxt = ST_IDLE;
              pend_c_nxt      = '0;
              pend_r_nxt      = '0;
              pend_last_nxt   = 1'b0;
              pend_stuck_nxt  = 1'b0;
            end
            default: ram_we = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          tracing_nxt     = 1'b1;
          cur_c_nxt       = base_c_r;
          cur_r_nxt       = base_r_r;
          init_c_nxt      = base_c_r;
          init_r_nxt      = base_r_r;
          heading_nxt     = DIR_RIGHT;
          pend_status_nxt = ST_FOUND;
          pend_c_nxt      = base_c_r;
          pend_r_nxt      = base_r_r;
        end else if (scan_miss && !scan_none) begin
          probe_k_nxt = PROBE_FIRST;
          if (col_end) begin
            base_c_nxt = scan_c0_r;
            base_r_nxt = base_r_r + POS_W'(1);
          end else begin
            base_c_nxt = base_c_r + POS_W'(1);
          end
        end else if (!scan_none) begin
          probe_k_nxt = probe_k_r + 3'd1;
        end
      end
      S_STEP: begin
        if (step_move) begin
          cur_c_nxt       = cand_pos.c[POS_W-1:0];
          cur_r_nxt       = cand_pos.r[POS_W-1:0];
          heading_nxt     = cand_dir;
          tracing_nxt     = !back;
          pend_status_nxt = ST_POINT;
          pend_c_nxt      = base_c_r;
          pend_r_nxt      = base_r_r;
          pend_last_nxt   = back;
          pend_stuck_nxt  = 1'b0;
        end else if (step_stuck) begin
          tracing_nxt     = 1'b0;
          pend_status_nxt = ST_POINT;
          pend_c_nxt      = base_c_r;
          pend_r_nxt      = base_r_r;
          pend_last_nxt   = 1'b1;
          pend_stuck_nxt  = 1'b1;
        end else if (probe_k_r[0] || hit) begin
          probe_k_nxt = probe_k_r + 3'd1;
        end else begin
          probe_k_nxt = probe_k_r + 3'd2;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_c_nxt      = pend_c_r;
          out_r_nxt      = pend_r_r;
          out_last_nxt   = pend_last_r;
          out_stuck_nxt  = pend_stuck_r;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    center = (state_nxt == S_SCAN) && (probe_k_nxt == PROBE_FIRST);
    if (state_nxt == S_SCAN) begin
      probe_dir = 2'(probe_k_nxt - 3'd1);
    end else begin
      probe_dir = 2'(heading_r + 2'd3 + probe_k_nxt[2:1] + {1'b0, probe_k_nxt[0]});
    end
    if (center) begin
      probe_pos.c = {1'b0, base_c_nxt};
      probe_pos.r = {1'b0, base_r_nxt};
    end else begin
      probe_pos = probe_coord(base_c_nxt, base_r_nxt, probe_dir);
    end
    probe_in_nxt = (probe_pos.c < used_w) && (probe_pos.r < used_h);
    rd_addr      = pix_addr(probe_pos.c[POS_W-1:0], probe_pos.r[POS_W-1:0]);
  end

  rct_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PIX_DEPTH)
  ) u_pixels (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pix_addr(in_column, in_row)),
    .wr_data (in_color),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= MAX_W_SZ;
      height_r    <= MAX_H_SZ;
      tracing_r   <= 1'b0;
      cur_c_r     <= '0;
      cur_r_r     <= '0;
      init_c_r    <= '0;
      init_r_r    <= '0;
      heading_r   <= DIR_RIGHT;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tracing_r   <= tracing_nxt;
      cur_c_r     <= cur_c_nxt;
      cur_r_r     <= cur_r_nxt;
      init_c_r    <= init_c_nxt;
      init_r_r    <= init_r_nxt;
      heading_r   <= heading_nxt;
      target_r    <= target_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en && cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_write_en && cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_c_r      <= base_c_nxt;
    base_r_r      <= base_r_nxt;
    scan_c0_r     <= scan_c0_nxt;
    probe_k_r     <= probe_k_nxt;
    probe_in_r    <= probe_in_nxt;
    pend_status_r <= pend_status_nxt;
    pend_c_r      <= pend_c_nxt;
    pend_r_r      <= pend_r_nxt;
    pend_last_r   <= pend_last_nxt;
    pend_stuck_r  <= pend_stuck_nxt;
    out_status_r  <= out_status_nxt;
    out_c_r       <= out_c_nxt;
    out_r_r       <= out_r_nxt;
    out_last_r    <= out_last_nxt;
    out_stuck_r   <= out_stuck_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_point_column = out_c_r;
  assign out_point_row    = out_r_r;
  assign out_last         = out_last_r;
  assign out_stuck        = out_stuck_r;

  a_last_is_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_status == ST_POINT)
    else $error("last flag on a beat that is not a contour point");

  a_stuck_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stuck |-> out_last)
    else $error("stuck flag without last flag");

  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_EMIT)
    else $error("result beat raised outside the emit state");

endmodule
